// ===== hw/rtl/thermistor_filter_and_linearize_unit_defines.svh =====
// Assertion helpers shared by the RTL files.
// Both expect clk_i and rst_ni in scope.
`ifndef THERMISTOR_FILTER_AND_LINEARIZE_UNIT_DEFINES_SVH
`define THERMISTOR_FILTER_AND_LINEARIZE_UNIT_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define TFL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition must never be true outside reset.
`define TFL_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ===== hw/rtl/tfl_pkg.sv =====
`default_nettype none

package tfl_pkg;

  // Default structural parameters
  localparam int TABLE_DEPTH = 256;
  localparam int WINDOW_SIZE = 6;

  // Field widths
  localparam int RAW_W      = 12;
  localparam int SAMPLE_W   = 10;
  localparam int IDX_W      = 8;
  localparam int TLEN_W     = 9;
  localparam int PERSIST_W  = 8;
  localparam int SCALE_W    = 7;
  localparam int TEMP_W     = 15;
  localparam int FAULT_W    = 2;
  localparam int SUM_W      = 13;
  localparam int CNT_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  // Multiplier operand covers a table index (up to 10 bits) or a sample difference
  localparam int OPND_W     = 10;
  localparam int PROD_W     = SCALE_W + OPND_W;

  // Configuration register indexes
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_TABLE_LENGTH   = 3'd0;
  localparam cfg_idx_t CFG_HIGH_LIMIT     = 3'd1;
  localparam cfg_idx_t CFG_LOW_LIMIT      = 3'd2;
  localparam cfg_idx_t CFG_PERSIST_LIMIT  = 3'd3;
  localparam cfg_idx_t CFG_TEMP_SCALE     = 3'd4;

  // Configuration reset values
  localparam logic [TLEN_W-1:0]    TABLE_LENGTH_RST  = 9'd174;
  localparam logic [SAMPLE_W-1:0]  HIGH_LIMIT_RST    = 10'd1010;
  localparam logic [SAMPLE_W-1:0]  LOW_LIMIT_RST     = 10'd6;
  localparam logic [PERSIST_W-1:0] PERSIST_LIMIT_RST = 8'd30;
  localparam logic [SCALE_W-1:0]   TEMP_SCALE_RST    = 7'd10;

  // Fault kinds
  localparam logic [FAULT_W-1:0] FAULT_NONE = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_LOW  = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_HIGH = 2'd2;

  localparam logic [TEMP_W-1:0]    TEMP_MAX   = 15'h7fff;
  localparam logic [SAMPLE_W-1:0]  SAMPLE_MAX = 10'h3ff;
  localparam logic [PERSIST_W-1:0] BAD_MAX    = 8'hff;

  // Table entry write toward the linearizer
  typedef struct packed {
    logic                en;
    logic [IDX_W-1:0]    idx;
    logic [SAMPLE_W-1:0] value;
  } tbl_wr_t;

  // Conversion request and response
  typedef struct packed {
    logic                start;
    logic [SAMPLE_W-1:0] value;
  } lin_req_t;

  typedef struct packed {
    logic              done;
    logic [TEMP_W-1:0] temp;
  } lin_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tfl_if.sv =====
`default_nettype none

// Input channel: ADC samples and table entry writes
interface tfl_in_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [tfl_pkg::RAW_W-1:0]    raw_sample;
  logic [tfl_pkg::IDX_W-1:0]    entry_index;
  logic [tfl_pkg::SAMPLE_W-1:0] entry_value;

  modport source (output valid, req_type, raw_sample, entry_index, entry_value,
                  input ready);
  modport sink   (input valid, req_type, raw_sample, entry_index, entry_value,
                  output ready);
endinterface

// Output channel: one item per ADC sample
interface tfl_out_if;
  logic                        valid;
  logic                        ready;
  logic                        temp_ready;
  logic [tfl_pkg::TEMP_W-1:0]  temperature;
  logic [tfl_pkg::FAULT_W-1:0] fault_status;

  modport source (output valid, temp_ready, temperature, fault_status, input ready);
  modport sink   (input valid, temp_ready, temperature, fault_status, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tfl_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module tfl_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [tfl_pkg::PROD_W-1:0]    dividend_i,
  input  wire logic [tfl_pkg::SAMPLE_W-1:0]  divisor_i,
  output logic                               done_o,
  output logic [tfl_pkg::PROD_W-1:0]         quotient_o
);

  localparam int CW = $clog2(tfl_pkg::PROD_W + 1);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [CW-1:0]                  cnt_q, cnt_d;
  logic [tfl_pkg::PROD_W-1:0]     quo_q, quo_d;
  logic [tfl_pkg::SAMPLE_W-1:0]   rem_q, rem_d;
  logic [tfl_pkg::SAMPLE_W-1:0]   dvs_q, dvs_d;
  logic [tfl_pkg::SAMPLE_W:0]     rem_sh;
  logic                           fits;

  // One shift-compare-subtract step
  assign rem_sh = {rem_q, quo_q[tfl_pkg::PROD_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(tfl_pkg::PROD_W);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? tfl_pkg::SAMPLE_W'(rem_sh - {1'b0, dvs_q})
                   : tfl_pkg::SAMPLE_W'(rem_sh);
      quo_d = {quo_q[tfl_pkg::PROD_W-2:0], fits};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      quo_q  <= quo_d;
      rem_q  <= rem_d;
      dvs_q  <= dvs_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tfl_linearizer.sv =====
`default_nettype none

`include "thermistor_filter_and_linearize_unit_defines.svh"

// Curve table, binary search and interpolation under one sequencer.
module tfl_linearizer #(
  parameter int TableDepth = tfl_pkg::TABLE_DEPTH
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire tfl_pkg::tbl_wr_t              wr_i,
  input  wire tfl_pkg::lin_req_t             req_i,
  input  wire logic [tfl_pkg::TLEN_W-1:0]    table_length_i,
  input  wire logic [tfl_pkg::SCALE_W-1:0]   temp_scale_i,
  output tfl_pkg::lin_rsp_t                  rsp_o
);

  localparam int AW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int NW = ($clog2(TableDepth + 1) > tfl_pkg::TLEN_W) ?
                      $clog2(TableDepth + 1) : tfl_pkg::TLEN_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD0, ST_RDHI, ST_SRCH, ST_PROBE, ST_RDCUR, ST_RDNXT,
    ST_MULB, ST_MULF, ST_DIV, ST_FIN
  } state_e;

  state_e                        state_q, state_d;
  logic [tfl_pkg::SAMPLE_W-1:0]  v_q, v_d;
  logic [AW-1:0]                 lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, idx_q, idx_d;
  logic [tfl_pkg::SAMPLE_W-1:0]  cur_q, cur_d, nxt_q, nxt_d;
  logic                          clamp_q, clamp_d;
  logic [tfl_pkg::PROD_W-1:0]    base_q, base_d, frac_q, frac_d;
  logic                          done_q, done_d;
  logic [tfl_pkg::TEMP_W-1:0]    temp_q, temp_d;

  logic [tfl_pkg::SAMPLE_W-1:0]  mem_q [TableDepth];
  logic [tfl_pkg::SAMPLE_W-1:0]  rd_q;
  logic [AW-1:0]                 rd_addr;
  logic                          wr_ok;
  logic [AW-1:0]                 wr_addr;

  logic [NW-1:0]                 tlen_ext, n_clamp;
  logic [AW-1:0]                 hi_n, half;
  logic [tfl_pkg::OPND_W-1:0]    mul_b;
  logic [tfl_pkg::PROD_W-1:0]    product;
  logic [tfl_pkg::PROD_W:0]      t_sum;
  logic                          div_start, div_done;
  logic [tfl_pkg::PROD_W-1:0]    div_quo;

  // Entries in use, clamped to the table
  assign tlen_ext = NW'(table_length_i);
  always_comb begin
    if (tlen_ext < NW'(2)) begin
      n_clamp = NW'(2);
    end else if (tlen_ext > NW'(TableDepth)) begin
      n_clamp = NW'(TableDepth);
    end else begin
      n_clamp = tlen_ext;
    end
  end
  assign hi_n = AW'(n_clamp - NW'(1));
  assign half = (hi_q - lo_q) >> 1;

  // Curve table: one write port, one registered read port
  assign wr_ok   = wr_i.en && (int'(wr_i.idx) < TableDepth);
  assign wr_addr = AW'(wr_i.idx);

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem_q[wr_addr] <= wr_i.value;
    end
    rd_q <= mem_q[rd_addr];
  end

  // Shared multiplier: scale times index, then scale times offset
  assign mul_b   = (state_q == ST_MULB) ? tfl_pkg::OPND_W'(idx_q)
                                        : tfl_pkg::OPND_W'(v_q - cur_q);
  assign product = tfl_pkg::PROD_W'(temp_scale_i) * tfl_pkg::PROD_W'(mul_b);

  assign div_start = (state_q == ST_MULF) && (nxt_q > cur_q) && (v_q > cur_q);

  tfl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (product),
    .divisor_i  (nxt_q - cur_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign t_sum = {1'b0, base_q} + {1'b0, frac_q};

  // Sequencer
  always_comb begin
    state_d = state_q;
    v_d     = v_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    idx_d   = idx_q;
    cur_d   = cur_q;
    nxt_d   = nxt_q;
    clamp_d = clamp_q;
    base_d  = base_q;
    frac_d  = frac_q;
    done_d  = 1'b0;
    temp_d  = temp_q;
    rd_addr = idx_q;
    case (state_q)
      ST_IDLE: begin
        rd_addr = '0;
        if (req_i.start) begin
          v_d     = req_i.value;
          lo_d    = '0;
          hi_d    = hi_n;
          state_d = ST_RD0;
        end
      end
      ST_RD0: begin
        rd_addr = hi_q;
        if (v_q <= rd_q) begin
          temp_d  = '0;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_RDHI;
        end
      end
      ST_RDHI: begin
        if (v_q >= rd_q) begin
          idx_d   = hi_q;
          clamp_d = 1'b1;
          state_d = ST_MULB;
        end else begin
          clamp_d = 1'b0;
          state_d = ST_SRCH;
        end
      end
      ST_SRCH: begin
        rd_addr = lo_q + half;
        if (half == '0) begin
          idx_d   = lo_q;
          state_d = ST_RDCUR;
        end else begin
          mid_d   = lo_q + half;
          state_d = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (v_q > rd_q) begin
          lo_d    = mid_q;
          state_d = ST_SRCH;
        end else if (v_q < rd_q) begin
          hi_d    = mid_q;
          state_d = ST_SRCH;
        end else begin
          idx_d   = mid_q;
          state_d = ST_RDCUR;
        end
      end
      ST_RDCUR: begin
        rd_addr = idx_q;
        state_d = ST_RDNXT;
      end
      ST_RDNXT: begin
        cur_d   = rd_q;
        rd_addr = idx_q + AW'(1);
        state_d = ST_MULB;
      end
      ST_MULB: begin
        nxt_d  = rd_q;
        base_d = product;
        if (clamp_q) begin
          frac_d  = '0;
          state_d = ST_FIN;
        end else begin
          state_d = ST_MULF;
        end
      end
      ST_MULF: begin
        if (div_start) begin
          state_d = ST_DIV;
        end else begin
          frac_d  = '0;
          state_d = ST_FIN;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          frac_d  = div_quo;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        temp_d  = (t_sum > (tfl_pkg::PROD_W + 1)'(tfl_pkg::TEMP_MAX)) ?
                  tfl_pkg::TEMP_MAX : tfl_pkg::TEMP_W'(t_sum);
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      v_q     <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      mid_q   <= '0;
      idx_q   <= '0;
      cur_q   <= '0;
      nxt_q   <= '0;
      clamp_q <= 1'b0;
      base_q  <= '0;
      frac_q  <= '0;
      done_q  <= 1'b0;
      temp_q  <= '0;
    end else begin
      state_q <= state_d;
      v_q     <= v_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      mid_q   <= mid_d;
      idx_q   <= idx_d;
      cur_q   <= cur_d;
      nxt_q   <= nxt_d;
      clamp_q <= clamp_d;
      base_q  <= base_d;
      frac_q  <= frac_d;
      done_q  <= done_d;
      temp_q  <= temp_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.temp = temp_q;

  // Search bounds stay ordered while probing
  `TFL_ASSERT(a_lo_below_hi, (state_q == ST_SRCH || state_q == ST_PROBE) |-> lo_q < hi_q, "search bounds crossed")
  // A conversion only starts from idle
  `TFL_ASSERT(a_start_idle, req_i.start |-> state_q == ST_IDLE, "start while busy")
  // Divider finishes only while the sequencer waits for it
  `TFL_ASSERT(a_div_done_in_div, div_done |-> state_q == ST_DIV, "stray divider done")

endmodule

`default_nettype wire

// ===== hw/rtl/thermistor_filter_and_linearize_unit.sv =====
// Channel  | Dir | Handshake          | Item
// ---------+-----+--------------------+-----------------------------------------------
// in_ch    | in  | valid/ready        | req_type, raw_sample, entry_index, entry_value
// out_ch   | out | valid/ready        | temp_ready, temperature, fault_status
// cfg      | in  | cfg_we_i, no wait  | cfg_idx_i selects register, cfg_data_i
//
// A table write goes into the curve table and makes no output item. A sample
// that does not close a window loads the output register once it is free.
// A sample that closes a window runs the linearizer: a binary search over the
// n table entries through the single table read port, and the 17-step divider
// for the interpolation fraction.
// Reset is asynchronous, active low; the curve table has no reset and reads
// undefined until written. A result waiting for output space holds back further input.
`default_nettype none

`include "thermistor_filter_and_linearize_unit_defines.svh"

module thermistor_filter_and_linearize_unit #(
  parameter int TableDepth = tfl_pkg::TABLE_DEPTH,
  parameter int WindowSize = tfl_pkg::WINDOW_SIZE
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  tfl_in_if.sink                               in_ch,
  tfl_out_if.source                            out_ch,
  input  wire logic                            cfg_we_i,
  input  wire logic [tfl_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [tfl_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  typedef enum logic [1:0] {ST_IDLE, ST_LIN, ST_PUSH} state_e;

  state_e                          state_q, state_d;

  // Configuration
  logic [tfl_pkg::TLEN_W-1:0]      tlen_q;
  logic [tfl_pkg::SAMPLE_W-1:0]    hi_lim_q, lo_lim_q;
  logic [tfl_pkg::PERSIST_W-1:0]   persist_q;
  logic [tfl_pkg::SCALE_W-1:0]     scale_q;

  // Filter and fault state
  logic [tfl_pkg::SUM_W-1:0]       sum_q, sum_d;
  logic [tfl_pkg::SAMPLE_W-1:0]    max_q, max_d, min_q, min_d;
  logic [tfl_pkg::CNT_W-1:0]       cnt_q, cnt_d;
  logic [tfl_pkg::PERSIST_W-1:0]   bad_q, bad_d;
  logic [tfl_pkg::FAULT_W-1:0]     kind_q, kind_d;
  logic [tfl_pkg::TEMP_W-1:0]      held_q, held_d;

  // Pending result and output register
  logic                            res_rdy_q, res_rdy_d;
  logic [tfl_pkg::FAULT_W-1:0]     res_fault_q, res_fault_d;
  logic                            out_valid_q, out_valid_d;
  logic                            out_rdy_q, out_rdy_d;
  logic [tfl_pkg::TEMP_W-1:0]      out_temp_q, out_temp_d;
  logic [tfl_pkg::FAULT_W-1:0]     out_fault_q, out_fault_d;

  logic                            in_acc, out_free, out_load;
  logic [tfl_pkg::SAMPLE_W-1:0]    s, max_n, min_n, avg;
  logic [tfl_pkg::SUM_W-1:0]       sum_n, trim;
  logic [tfl_pkg::CNT_W-1:0]       cnt_n;
  logic [tfl_pkg::FAULT_W-1:0]     status;
  tfl_pkg::tbl_wr_t                tbl_wr;
  tfl_pkg::lin_req_t               lin_req;
  tfl_pkg::lin_rsp_t               lin_rsp;

  assign in_ch.ready = (state_q == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_q || out_ch.ready;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tlen_q    <= tfl_pkg::TABLE_LENGTH_RST;
      hi_lim_q  <= tfl_pkg::HIGH_LIMIT_RST;
      lo_lim_q  <= tfl_pkg::LOW_LIMIT_RST;
      persist_q <= tfl_pkg::PERSIST_LIMIT_RST;
      scale_q   <= tfl_pkg::TEMP_SCALE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tfl_pkg::CFG_TABLE_LENGTH:  tlen_q    <= cfg_data_i[tfl_pkg::TLEN_W-1:0];
        tfl_pkg::CFG_HIGH_LIMIT:    hi_lim_q  <= cfg_data_i[tfl_pkg::SAMPLE_W-1:0];
        tfl_pkg::CFG_LOW_LIMIT:     lo_lim_q  <= cfg_data_i[tfl_pkg::SAMPLE_W-1:0];
        tfl_pkg::CFG_PERSIST_LIMIT: persist_q <= cfg_data_i[tfl_pkg::PERSIST_W-1:0];
        tfl_pkg::CFG_TEMP_SCALE:    scale_q   <= cfg_data_i[tfl_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Sample reduction and window arithmetic
  assign s     = in_ch.raw_sample[tfl_pkg::RAW_W-1:2];
  assign max_n = (s > max_q) ? s : max_q;
  assign min_n = (s < min_q) ? s : min_q;
  assign sum_n = sum_q + tfl_pkg::SUM_W'(s);
  assign cnt_n = cnt_q + tfl_pkg::CNT_W'(1);
  assign trim  = sum_n - tfl_pkg::SUM_W'(max_n) - tfl_pkg::SUM_W'(min_n);
  assign avg   = trim[tfl_pkg::SAMPLE_W+1:2];

  assign tbl_wr.en    = in_acc && in_ch.req_type;
  assign tbl_wr.idx   = in_ch.entry_index;
  assign tbl_wr.value = in_ch.entry_value;

  assign lin_req.value = avg;

  tfl_linearizer #(
    .TableDepth (TableDepth)
  ) u_lin (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .wr_i           (tbl_wr),
    .req_i          (lin_req),
    .table_length_i (tlen_q),
    .temp_scale_i   (scale_q),
    .rsp_o          (lin_rsp)
  );

  // Item handling
  always_comb begin
    state_d       = state_q;
    sum_d         = sum_q;
    max_d         = max_q;
    min_d         = min_q;
    cnt_d         = cnt_q;
    bad_d         = bad_q;
    kind_d        = kind_q;
    held_d        = held_q;
    res_rdy_d     = res_rdy_q;
    res_fault_d   = res_fault_q;
    out_load      = 1'b0;
    out_rdy_d     = out_rdy_q;
    out_temp_d    = out_temp_q;
    out_fault_d   = out_fault_q;
    lin_req.start = 1'b0;
    status        = tfl_pkg::FAULT_NONE;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && !in_ch.req_type) begin
          if (s > hi_lim_q) begin
            bad_d  = (bad_q == tfl_pkg::BAD_MAX) ? bad_q : bad_q + 8'd1;
            kind_d = tfl_pkg::FAULT_HIGH;
          end else if (s < lo_lim_q) begin
            bad_d  = (bad_q == tfl_pkg::BAD_MAX) ? bad_q : bad_q + 8'd1;
            kind_d = tfl_pkg::FAULT_LOW;
          end else begin
            bad_d  = '0;
            kind_d = tfl_pkg::FAULT_NONE;
            if (cnt_n >= tfl_pkg::CNT_W'(WindowSize)) begin
              sum_d = '0;
              max_d = '0;
              min_d = tfl_pkg::SAMPLE_MAX;
              cnt_d = '0;
              lin_req.start = 1'b1;
            end else begin
              sum_d = sum_n;
              max_d = max_n;
              min_d = min_n;
              cnt_d = cnt_n;
            end
          end
          status      = (bad_d > persist_q) ? kind_d : tfl_pkg::FAULT_NONE;
          res_fault_d = status;
          res_rdy_d   = lin_req.start;
          if (lin_req.start) begin
            state_d = ST_LIN;
          end else if (out_free) begin
            out_load    = 1'b1;
            out_rdy_d   = 1'b0;
            out_temp_d  = held_q;
            out_fault_d = status;
          end else begin
            state_d = ST_PUSH;
          end
        end
      end
      ST_LIN: begin
        if (lin_rsp.done) begin
          held_d = lin_rsp.temp;
          if (out_free) begin
            out_load    = 1'b1;
            out_rdy_d   = res_rdy_q;
            out_temp_d  = lin_rsp.temp;
            out_fault_d = res_fault_q;
            state_d     = ST_IDLE;
          end else begin
            state_d = ST_PUSH;
          end
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_rdy_d   = res_rdy_q;
          out_temp_d  = held_q;
          out_fault_d = res_fault_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    out_valid_d = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      max_q       <= '0;
      min_q       <= tfl_pkg::SAMPLE_MAX;
      cnt_q       <= '0;
      bad_q       <= '0;
      kind_q      <= tfl_pkg::FAULT_NONE;
      held_q      <= '0;
      res_rdy_q   <= 1'b0;
      res_fault_q <= tfl_pkg::FAULT_NONE;
      out_valid_q <= 1'b0;
      out_rdy_q   <= 1'b0;
      out_temp_q  <= '0;
      out_fault_q <= tfl_pkg::FAULT_NONE;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      max_q       <= max_d;
      min_q       <= min_d;
      cnt_q       <= cnt_d;
      bad_q       <= bad_d;
      kind_q      <= kind_d;
      held_q      <= held_d;
      res_rdy_q   <= res_rdy_d;
      res_fault_q <= res_fault_d;
      out_valid_q <= out_valid_d;
      out_rdy_q   <= out_rdy_d;
      out_temp_q  <= out_temp_d;
      out_fault_q <= out_fault_d;
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.temp_ready   = out_rdy_q;
  assign out_ch.temperature  = out_temp_q;
  assign out_ch.fault_status = out_fault_q;

  // A waiting result is never overwritten
  `TFL_ASSERT_NEVER(a_no_overwrite, out_load && out_valid_q && !out_ch.ready, "output item overwritten")
  // Window fill stays below the window size
  `TFL_ASSERT(a_cnt_range, cnt_q < tfl_pkg::CNT_W'(WindowSize), "window count out of range")
  // Held temperature moves only when a conversion finishes
  `TFL_ASSERT(a_held_stable, !lin_rsp.done |=> $stable(held_q), "held temperature changed")

endmodule

`default_nettype wire
